>>> src/vpcn_pkg.sv
`timescale 1ns / 1ps
// Package for the vector path command normalizer.
// Command and event codes and the result entry type; no dependencies.
package vpcn_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned NUM_FLDS  = 10;

    localparam logic [3:0] FN_CLOSE  = 4'd0;
    localparam logic [3:0] FN_MOVE   = 4'd1;
    localparam logic [3:0] FN_LINE   = 4'd2;
    localparam logic [3:0] FN_HLINE  = 4'd3;
    localparam logic [3:0] FN_VLINE  = 4'd4;
    localparam logic [3:0] FN_QUAD   = 4'd5;
    localparam logic [3:0] FN_CUBIC  = 4'd6;
    localparam logic [3:0] FN_SQUAD  = 4'd7;
    localparam logic [3:0] FN_SCUBIC = 4'd8;
    localparam logic [3:0] FN_ARC_LO = 4'd9;
    localparam logic [3:0] FN_ARC_HI = 4'd12;

    localparam logic [2:0] EV_START      = 3'd0;
    localparam logic [2:0] EV_LINE       = 3'd1;
    localparam logic [2:0] EV_QUAD       = 3'd2;
    localparam logic [2:0] EV_CUBIC      = 3'd3;
    localparam logic [2:0] EV_ARC        = 3'd4;
    localparam logic [2:0] EV_END_OPEN   = 3'd5;
    localparam logic [2:0] EV_END_CLOSED = 3'd6;
    localparam logic [2:0] EV_BAD        = 3'd7;

    // fld[0..5]: px1 py1 px2 py2 px3 py3, fld[6..9]: min x, min y, max x, max y
    typedef struct packed {
        logic [2:0]                           ev;
        logic                                 is_last;
        logic [NUM_FLDS-1:0][WORD_BITS-1:0]   fld;
    } t_res;

endpackage

>>> src/vector_path_command_normalizer.sv
`timescale 1ns / 1ps
// Vector path command normalizer: absolute coordinates, smooth control
// reflection, subpath and path bounding boxes, start/segment/end/bad events.
// Depends on vpcn_pkg.
//
//  channel | dir | tdata (low bit up)                     | tuser      | tlast
//  s       | in  | coord_a0 .. coord_a5 (6 x 32)           | func, rel  | path_end
//  m       | out | px1 py1 px2 py2 px3 py3, box min x/y,    | event_res  | last
//          |     | box max x/y (10 x 32)                   |            |
//
// One command is decoded, normalized and its state updated in the cycle it
// is accepted; its zero to three results go into a three-entry result
// register and leave one per cycle while the output is ready. Single-result
// commands stream at one per cycle while the output is ready. Reset
// (synchronous, active low) clears all path state and empties the result
// register. A stalled output holds its result; a new command is taken only
// when no result is pending or the last pending one leaves in that cycle.
module vector_path_command_normalizer
    import vpcn_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [191:0]   i_s_tdata,   // coord_a0, coord_a1, ..., coord_a5
    input  logic [4:0]     i_s_tuser,   // func[3:0], rel[4]
    input  logic           i_s_tlast,   // path_end
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [319:0]   o_m_tdata,   // px1 py1 px2 py2 px3 py3 min_x min_y max_x max_y
    output logic [2:0]     o_m_tuser,   // event_res
    output logic           o_m_tlast    // last
);

    localparam int CW = COORD_BITS;
    localparam int SW = ((CW > 32) ? CW : 32) + 2;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    function automatic logic signed [SW-1:0] ext_w(input logic [31:0] v);
        return {{(SW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] ext_c(input logic [CW-1:0] v);
        return {{(SW-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[CW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] to32(input logic [CW-1:0] v);
        logic [SW-1:0] t;
        t = ext_c(v);
        return t[31:0];
    endfunction

    function automatic logic signed [CW-1:0] add_c(input logic [31:0] a,
                                                    input logic [CW-1:0] o);
        return sat(ext_w(a) + ext_c(o));
    endfunction

    function automatic logic signed [CW-1:0] refl(input logic [CW-1:0] c,
                                                   input logic [CW-1:0] k);
        return sat((ext_c(c) <<< 1) - ext_c(k));
    endfunction

    function automatic logic signed [CW-1:0] lo_of(input logic signed [CW-1:0] b,
                                                    input logic signed [CW-1:0] v,
                                                    input logic en);
        return (en && (v < b)) ? v : b;
    endfunction

    function automatic logic signed [CW-1:0] hi_of(input logic signed [CW-1:0] b,
                                                    input logic signed [CW-1:0] v,
                                                    input logic en);
        return (en && (v > b)) ? v : b;
    endfunction

    // path state
    logic signed [CW-1:0] r_cx, r_cy, r_kx, r_ky;
    logic signed [CW-1:0] r_sb_x0, r_sb_y0, r_sb_x1, r_sb_y1;
    logic signed [CW-1:0] r_pb_x0, r_pb_y0, r_pb_x1, r_pb_y1;
    logic                 r_open, r_pb_vld;
    logic signed [CW-1:0] n_cx, n_cy, n_kx, n_ky;
    logic signed [CW-1:0] n_pb_x0, n_pb_y0, n_pb_x1, n_pb_y1;
    logic                 n_open, n_pb_vld;

    // result register
    t_res       r_slot0, r_slot1, r_slot2;
    logic [1:0] r_cnt;

    logic [3:0]  in_func;
    logic        in_rel, in_pe;
    logic [31:0] a0, a1, a2, a3, a4, a5;
    logic        s_acc, m_take;
    logic        is_close, is_move, is_draw, is_bad;
    logic        is_line, is_quad, is_cubic, is_arc, is_smooth;
    logic signed [CW-1:0] ox, oy;
    logic signed [CW-1:0] ax0, ay1, ax2, ay3, ax4, ay5, ay0, ax3, ay4, rx, ry;
    logic signed [CW-1:0] q1x, q1y, q2x, q2y, q3x, q3y;
    logic                 g1, g2, g3;
    logic signed [CW-1:0] b_x0, b_y0, b_x1, b_y1;
    logic signed [CW-1:0] sb_x0, sb_y0, sb_x1, sb_y1;
    logic signed [CW-1:0] mg_x0, mg_y0, mg_x1, mg_y1;
    logic                 open_cmd, ended;
    t_res                 res_a, res_b, res_c, end_res;
    logic                 v_a, v_b, v_c;
    t_res                 n_slot0, n_slot1, n_slot2;
    logic [1:0]           n_cnt;

    assign in_func = i_s_tuser[3:0];
    assign in_rel  = i_s_tuser[4];
    assign in_pe   = i_s_tlast;
    assign a0 = i_s_tdata[0*32 +: 32];
    assign a1 = i_s_tdata[1*32 +: 32];
    assign a2 = i_s_tdata[2*32 +: 32];
    assign a3 = i_s_tdata[3*32 +: 32];
    assign a4 = i_s_tdata[4*32 +: 32];
    assign a5 = i_s_tdata[5*32 +: 32];

    assign o_s_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign m_take     = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = r_slot0.fld;
    assign o_m_tuser  = r_slot0.ev;
    assign o_m_tlast  = r_slot0.is_last;

    // decode
    assign is_close  = (in_func == FN_CLOSE);
    assign is_move   = (in_func == FN_MOVE);
    assign is_bad    = (in_func > FN_ARC_HI);
    assign is_draw   = !is_close && !is_move && !is_bad;
    assign is_line   = (in_func == FN_LINE) || (in_func == FN_HLINE) || (in_func == FN_VLINE);
    assign is_quad   = (in_func == FN_QUAD) || (in_func == FN_SQUAD);
    assign is_cubic  = (in_func == FN_CUBIC) || (in_func == FN_SCUBIC);
    assign is_arc    = (in_func >= FN_ARC_LO) && (in_func <= FN_ARC_HI);
    assign is_smooth = (in_func == FN_SQUAD) || (in_func == FN_SCUBIC);

    // coordinates
    assign ox  = in_rel ? r_cx : '0;
    assign oy  = in_rel ? r_cy : '0;
    assign ax0 = add_c(a0, ox);
    assign ay1 = add_c(a1, oy);
    assign ax2 = add_c(a2, ox);
    assign ay3 = add_c(a3, oy);
    assign ax4 = add_c(a4, ox);
    assign ay5 = add_c(a5, oy);
    assign ay0 = add_c(a0, oy);
    assign ax3 = add_c(a3, ox);
    assign ay4 = add_c(a4, oy);
    assign rx  = refl(r_cx, r_kx);
    assign ry  = refl(r_cy, r_ky);

    always_comb begin
        q1x = ax0;
        q1y = ay1;
        q2x = ax2;
        q2y = ay3;
        q3x = ax4;
        q3y = ay5;
        if (is_line) begin
            q1x = (in_func == FN_VLINE) ? r_cx : ax0;
            q1y = (in_func == FN_HLINE) ? r_cy : ((in_func == FN_VLINE) ? ay0 : ay1);
        end else if (is_smooth) begin
            q1x = rx;
            q1y = ry;
            q2x = ax0;
            q2y = ay1;
            q3x = ax2;
            q3y = ay3;
        end else if (is_arc) begin
            q3x = ax3;
            q3y = ay4;
        end
    end

    assign g1 = is_line || is_quad || is_cubic;
    assign g2 = is_quad || is_cubic;
    assign g3 = is_cubic || is_arc;

    // subpath box
    assign b_x0 = r_open ? r_sb_x0 : r_cx;
    assign b_y0 = r_open ? r_sb_y0 : r_cy;
    assign b_x1 = r_open ? r_sb_x1 : r_cx;
    assign b_y1 = r_open ? r_sb_y1 : r_cy;

    assign sb_x0 = is_draw ? lo_of(lo_of(lo_of(b_x0, q1x, g1), q2x, g2), q3x, g3) : r_sb_x0;
    assign sb_y0 = is_draw ? lo_of(lo_of(lo_of(b_y0, q1y, g1), q2y, g2), q3y, g3) : r_sb_y0;
    assign sb_x1 = is_draw ? hi_of(hi_of(hi_of(b_x1, q1x, g1), q2x, g2), q3x, g3) : r_sb_x1;
    assign sb_y1 = is_draw ? hi_of(hi_of(hi_of(b_y1, q1y, g1), q2y, g2), q3y, g3) : r_sb_y1;

    assign mg_x0 = r_pb_vld ? lo_of(r_pb_x0, sb_x0, 1'b1) : sb_x0;
    assign mg_y0 = r_pb_vld ? lo_of(r_pb_y0, sb_y0, 1'b1) : sb_y0;
    assign mg_x1 = r_pb_vld ? hi_of(r_pb_x1, sb_x1, 1'b1) : sb_x1;
    assign mg_y1 = r_pb_vld ? hi_of(r_pb_y1, sb_y1, 1'b1) : sb_y1;

    // results
    always_comb begin
        end_res        = '0;
        end_res.ev     = EV_END_OPEN;
        end_res.fld[6] = to32(mg_x0);
        end_res.fld[7] = to32(mg_y0);
        end_res.fld[8] = to32(mg_x1);
        end_res.fld[9] = to32(mg_y1);

        res_a = end_res;
        v_a   = 1'b0;
        if (is_close) begin
            res_a.ev = EV_END_CLOSED;
            v_a      = r_open;
        end else if (is_move) begin
            v_a = r_open;
        end else if (is_draw) begin
            res_a        = '0;
            res_a.ev     = EV_START;
            res_a.fld[0] = to32(r_cx);
            res_a.fld[1] = to32(r_cy);
            v_a          = !r_open;
        end else begin
            res_a    = '0;
            res_a.ev = EV_BAD;
            v_a      = 1'b1;
        end

        res_b = end_res;
        v_b   = is_bad && in_pe && r_open;
        if (is_draw) begin
            res_b = '0;
            v_b   = 1'b1;
            if (is_arc) begin
                res_b.ev     = EV_ARC;
                res_b.fld[0] = a0;
                res_b.fld[1] = a1;
                res_b.fld[2] = a2;
                res_b.fld[4] = to32(q3x);
                res_b.fld[5] = to32(q3y);
            end else begin
                res_b.ev     = is_line ? EV_LINE : (is_quad ? EV_QUAD : EV_CUBIC);
                res_b.fld[0] = to32(q1x);
                res_b.fld[1] = to32(q1y);
                if (g2) begin
                    res_b.fld[2] = to32(q2x);
                    res_b.fld[3] = to32(q2y);
                end
                if (is_cubic) begin
                    res_b.fld[4] = to32(q3x);
                    res_b.fld[5] = to32(q3y);
                end
            end
        end

        res_c = end_res;
        v_c   = is_draw && in_pe;

        res_a.is_last = v_a && !v_b && !v_c;
        res_b.is_last = v_b && !v_c;
        res_c.is_last = v_c;

        n_slot0 = v_a ? res_a : (v_b ? res_b : res_c);
        n_slot1 = v_a ? (v_b ? res_b : res_c) : res_c;
        n_slot2 = res_c;
        n_cnt   = {1'b0, v_a} + {1'b0, v_b} + {1'b0, v_c};
    end

    // next path state
    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_kx     = r_kx;
        n_ky     = r_ky;
        open_cmd = r_open;
        if (is_close) begin
            open_cmd = 1'b0;
        end else if (is_move) begin
            open_cmd = 1'b0;
            n_cx     = ax0;
            n_cy     = ay1;
            n_kx     = ax0;
            n_ky     = ay1;
        end else if (is_draw) begin
            open_cmd = 1'b1;
            n_cx = is_line ? q1x : (is_quad ? q2x : q3x);
            n_cy = is_line ? q1y : (is_quad ? q2y : q3y);
            n_kx = (is_line || is_quad) ? q1x : (is_cubic ? q2x : q3x);
            n_ky = (is_line || is_quad) ? q1y : (is_cubic ? q2y : q3y);
        end
        ended    = ((is_close || is_move) && r_open) || (in_pe && open_cmd);
        n_open   = open_cmd && !in_pe;
        n_pb_x0  = r_pb_x0;
        n_pb_y0  = r_pb_y0;
        n_pb_x1  = r_pb_x1;
        n_pb_y1  = r_pb_y1;
        n_pb_vld = r_pb_vld;
        if (in_pe) begin
            n_cx     = '0;
            n_cy     = '0;
            n_kx     = '0;
            n_ky     = '0;
            n_pb_x0  = '0;
            n_pb_y0  = '0;
            n_pb_x1  = '0;
            n_pb_y1  = '0;
            n_pb_vld = 1'b0;
        end else if (ended) begin
            n_pb_x0  = mg_x0;
            n_pb_y0  = mg_y0;
            n_pb_x1  = mg_x1;
            n_pb_y1  = mg_y1;
            n_pb_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_kx     <= '0;
            r_ky     <= '0;
            r_sb_x0  <= '0;
            r_sb_y0  <= '0;
            r_sb_x1  <= '0;
            r_sb_y1  <= '0;
            r_pb_x0  <= '0;
            r_pb_y0  <= '0;
            r_pb_x1  <= '0;
            r_pb_y1  <= '0;
            r_open   <= 1'b0;
            r_pb_vld <= 1'b0;
        end else if (s_acc) begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_kx     <= n_kx;
            r_ky     <= n_ky;
            r_sb_x0  <= sb_x0;
            r_sb_y0  <= sb_y0;
            r_sb_x1  <= sb_x1;
            r_sb_y1  <= sb_y1;
            r_pb_x0  <= n_pb_x0;
            r_pb_y0  <= n_pb_y0;
            r_pb_x1  <= n_pb_x1;
            r_pb_y1  <= n_pb_y1;
            r_open   <= n_open;
            r_pb_vld <= n_pb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (s_acc) begin
            r_cnt <= n_cnt;
        end else if (m_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_slot0 <= n_slot0;
            r_slot1 <= n_slot1;
            r_slot2 <= n_slot2;
        end else if (m_take) begin
            r_slot0 <= r_slot1;
            r_slot1 <= r_slot2;
        end
    end

endmodule

>>> src/vpcn_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the vector path command normalizer, with bind.
// Depends on vpcn_pkg.
module vpcn_checker
    import vpcn_pkg::*;
(
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_m_tvalid,
    input logic           i_m_tready,
    input logic [319:0]   o_m_tdata,
    input logic [2:0]     o_m_tuser,
    input logic           o_m_tlast
);

    logic is_end;
    assign is_end = (o_m_tuser == EV_END_OPEN) || (o_m_tuser == EV_END_CLOSED);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_box_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !is_end |-> o_m_tdata[319:192] == '0)
        else $error("box fields set on non-end event");

    a_no_pts_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (is_end || (o_m_tuser == EV_BAD)) |-> o_m_tdata[191:0] == '0)
        else $error("point fields set on end or bad event");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == EV_START) |-> !o_m_tlast)
        else $error("start event marked last");

endmodule

bind vector_path_command_normalizer vpcn_checker u_vpcn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
